### hdl/tlrq_pkg.sv
// Shared types, codes and the granularity mask table for the timestamp log.
`timescale 1ns / 1ps

package tlrq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int STAMP_W   = 40;
  localparam int ID_W      = 32;
  localparam int GRAN_W    = 3;
  localparam int STAT_W    = 2;
  localparam int WORD_W    = ID_W + STAMP_W;

  // Command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_MATCH  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STORED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  // Granularity codes
  localparam logic [GRAN_W-1:0] GRAN_YEAR   = 3'd0;
  localparam logic [GRAN_W-1:0] GRAN_MONTH  = 3'd1;
  localparam logic [GRAN_W-1:0] GRAN_DAY    = 3'd2;
  localparam logic [GRAN_W-1:0] GRAN_HOUR   = 3'd3;
  localparam logic [GRAN_W-1:0] GRAN_MINUTE = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // One result transaction pushed into the output register
  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

  // Keeps the fields at and above the granularity; codes above minute compare
  // the full stamp.
  function automatic logic [STAMP_W-1:0] gran_mask(input logic [GRAN_W-1:0] g);
    logic [STAMP_W-1:0] m;
    case (g)
      GRAN_YEAR:   m = 40'hFFFC000000;
      GRAN_MONTH:  m = 40'hFFFFC00000;
      GRAN_DAY:    m = 40'hFFFFFE0000;
      GRAN_HOUR:   m = 40'hFFFFFFF000;
      GRAN_MINUTE: m = 40'hFFFFFFFFC0;
      default:     m = 40'hFFFFFFFFFF;
    endcase
    return m;
  endfunction

endpackage

### hdl/tlrq_ram.sv
// Record store: single-port-write, single-read synchronous RAM, registered read.
`timescale 1ns / 1ps

module tlrq_ram #(
  parameter int DEPTH = tlrq_pkg::DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tlrq_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [tlrq_pkg::WORD_W-1:0] rd_data
);

  logic [tlrq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [tlrq_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/tlrq_scan.sv
// Command sequencer: appends records and scans the store for range queries.
`timescale 1ns / 1ps

module tlrq_scan #(
  parameter int DEPTH = tlrq_pkg::DEPTH_DEF,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [tlrq_pkg::ID_W-1:0]    in_log_id,
  input  logic [tlrq_pkg::STAMP_W-1:0] in_stamp,
  input  logic [tlrq_pkg::STAMP_W-1:0] in_stamp_end,
  input  logic [tlrq_pkg::GRAN_W-1:0]  in_granularity,
  input  logic                         out_free,
  output tlrq_pkg::res_t               push,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [tlrq_pkg::WORD_W-1:0]  wr_data,
  output logic [AW-1:0]                rd_addr,
  input  logic [tlrq_pkg::WORD_W-1:0]  rd_data
);

  tlrq_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                scan_addr_r, scan_addr_nxt;
  logic                         d_vld_r, d_vld_nxt;
  logic [AW-1:0]                d_addr_r, d_addr_nxt;
  logic                         pend_vld_r, pend_vld_nxt;
  logic [tlrq_pkg::ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic [tlrq_pkg::STAMP_W-1:0] s_r, s_nxt, e_r, e_nxt, mask_r, mask_nxt;
  logic [tlrq_pkg::STAMP_W-1:0] in_mask, t_stamp;
  logic [tlrq_pkg::ID_W-1:0]    t_id;
  logic                         accept, hit, adv, issue, pending_out, scan_end;

  assign in_ready = (state_r == tlrq_pkg::S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign in_mask  = tlrq_pkg::gran_mask(in_granularity);

  assign t_id    = rd_data[tlrq_pkg::WORD_W-1:tlrq_pkg::STAMP_W];
  assign t_stamp = rd_data[tlrq_pkg::STAMP_W-1:0] & mask_r;
  assign hit     = d_vld_r && (t_stamp >= s_r) && (t_stamp <= e_r);
  // A second hit while one is held must hand the held one out first.
  assign adv      = !(hit && pend_vld_r && !out_free);
  assign pending_out = hit && pend_vld_r && out_free;
  assign issue    = (state_r == tlrq_pkg::S_SCAN) && adv && (scan_addr_r < cnt_r);
  assign scan_end = !d_vld_r && (scan_addr_r >= cnt_r);

  // Hold the read address on a stall so the same word is presented again.
  assign rd_addr = adv ? scan_addr_r[AW-1:0] : d_addr_r;

  assign wr_en   = accept && (in_command == tlrq_pkg::CMD_STORE) && (cnt_r < CW'(DEPTH));
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = {in_log_id, in_stamp};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlrq_pkg::S_IDLE: begin
        if (accept && (in_command == tlrq_pkg::CMD_QUERY)) begin
          state_nxt = tlrq_pkg::S_SCAN;
        end
      end
      tlrq_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = tlrq_pkg::S_FIN;
        end
      end
      tlrq_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = tlrq_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlrq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    scan_addr_nxt = scan_addr_r;
    d_vld_nxt     = d_vld_r;
    d_addr_nxt    = d_addr_r;
    pend_vld_nxt  = pend_vld_r;
    pend_id_nxt   = pend_id_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    mask_nxt      = mask_r;
    push          = '0;
    case (state_r)
      tlrq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_command == tlrq_pkg::CMD_STORE) begin
            push.vld  = 1'b1;
            push.last = 1'b1;
            if (wr_en) begin
              cnt_nxt     = cnt_r + CW'(1);
              push.status = tlrq_pkg::STAT_STORED;
            end else begin
              push.status = tlrq_pkg::STAT_FULL;
            end
          end else begin
            s_nxt         = in_stamp & in_mask;
            e_nxt         = in_stamp_end & in_mask;
            mask_nxt      = in_mask;
            scan_addr_nxt = '0;
            d_vld_nxt     = 1'b0;
            pend_vld_nxt  = 1'b0;
          end
        end
      end
      tlrq_pkg::S_SCAN: begin
        if (adv) begin
          d_vld_nxt  = issue;
          d_addr_nxt = scan_addr_r[AW-1:0];
          if (issue) begin
            scan_addr_nxt = scan_addr_r + CW'(1);
          end
          if (hit) begin
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = t_id;
          end
        end
        if (pending_out) begin
          push.vld    = 1'b1;
          push.id     = pend_id_r;
          push.status = tlrq_pkg::STAT_MATCH;
          push.last   = 1'b0;
        end
      end
      tlrq_pkg::S_FIN: begin
        if (out_free) begin
          push.vld     = 1'b1;
          push.last    = 1'b1;
          push.id      = pend_vld_r ? pend_id_r : '0;
          push.status  = pend_vld_r ? tlrq_pkg::STAT_MATCH : tlrq_pkg::STAT_NONE;
          pend_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlrq_pkg::S_IDLE;
      cnt_r       <= '0;
      scan_addr_r <= '0;
      d_vld_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_addr_r <= scan_addr_nxt;
      d_vld_r     <= d_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_addr_r  <= d_addr_nxt;
    pend_id_r <= pend_id_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    mask_r    <= mask_nxt;
  end

endmodule

### hdl/timestamp_log_range_query.sv
// Top level of the timestamp log: record RAM, scan sequencer, output register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_ready  | command, log_id, stamp, stamp_end, granularity
//  out      | out_valid / out_ready| match_id, status, last
//
// A store transaction yields one result.
// A query reads one record per cycle from the RAM port while the output is not stalled.
// Reset empties the log (count to zero); RAM contents are not cleared.
// Output stalls hold the scan at the current record; a new transaction is
// accepted while a finished result is being taken.
`timescale 1ns / 1ps

module timestamp_log_range_query #(
  parameter int DEPTH = tlrq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [tlrq_pkg::ID_W-1:0]    in_log_id,
  input  logic [tlrq_pkg::STAMP_W-1:0] in_stamp,
  input  logic [tlrq_pkg::STAMP_W-1:0] in_stamp_end,
  input  logic [tlrq_pkg::GRAN_W-1:0]  in_granularity,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tlrq_pkg::ID_W-1:0]    out_match_id,
  output logic [tlrq_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last
);

  // Address width for the RAM; count width must also hold DEPTH itself.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                        wr_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [tlrq_pkg::WORD_W-1:0] wr_data, rd_data;
  tlrq_pkg::res_t              push;
  logic                        out_free;

  logic                        out_valid_r, out_valid_nxt;
  logic [tlrq_pkg::ID_W-1:0]   out_id_r;
  logic [tlrq_pkg::STAT_W-1:0] out_status_r;
  logic                        out_last_r;

  tlrq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlrq_scan #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_log_id      (in_log_id),
    .in_stamp       (in_stamp),
    .in_stamp_end   (in_stamp_end),
    .in_granularity (in_granularity),
    .out_free       (out_free),
    .push           (push),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push.vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      out_id_r     <= push.id;
      out_status_r <= push.status;
      out_last_r   <= push.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_match_id = out_id_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

endmodule

### verif/timestamp_log_range_query_checker.sv
// Scoreboard for the timestamp log: mirrors the record store and checks every result.
`timescale 1ns / 1ps

module timestamp_log_range_query_checker #(
  parameter int DEPTH = tlrq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_command,
  input  logic [tlrq_pkg::ID_W-1:0]    in_log_id,
  input  logic [tlrq_pkg::STAMP_W-1:0] in_stamp,
  input  logic [tlrq_pkg::STAMP_W-1:0] in_stamp_end,
  input  logic [tlrq_pkg::GRAN_W-1:0]  in_granularity,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tlrq_pkg::ID_W-1:0]    out_match_id,
  input  logic [tlrq_pkg::STAT_W-1:0]  out_status,
  input  logic                         out_last,
  output int                           err_cnt,
  output int                           results_owed,
  output int                           stores_kept,
  output int                           stores_dropped,
  output int                           queries_seen,
  output int                           ids_matched,
  output int                           queries_empty
);

  localparam int MAX_REPORTS = 10;
  localparam int OWED_DEPTH  = 1024;

  typedef struct packed {
    logic [tlrq_pkg::ID_W-1:0]   id;
    logic [tlrq_pkg::STAT_W-1:0] status;
    logic                        last;
  } log_result_t;

  logic [tlrq_pkg::STAMP_W-1:0] rec_stamp [DEPTH];
  logic [tlrq_pkg::ID_W-1:0]    rec_id    [DEPTH];
  int                           rec_count = 0;
  // expected results, kept as a ring in arrival order
  log_result_t                  owed_mem [OWED_DEPTH];
  int                           owed_wr = 0;
  int                           owed_rd = 0;
  log_result_t                  want;

  initial begin
    err_cnt        = 0;
    results_owed   = 0;
    stores_kept    = 0;
    stores_dropped = 0;
    queries_seen   = 0;
    ids_matched    = 0;
    queries_empty  = 0;
  end

  // Clears every field finer than the chosen granularity; codes past minute keep all.
  function automatic logic [tlrq_pkg::STAMP_W-1:0] granule_mask(
    input logic [tlrq_pkg::GRAN_W-1:0] g);
    logic [tlrq_pkg::STAMP_W-1:0] m;
    m = '1;
    if (g <= tlrq_pkg::GRAN_MINUTE) m[5:0]   = '0;
    if (g <= tlrq_pkg::GRAN_HOUR)   m[11:6]  = '0;
    if (g <= tlrq_pkg::GRAN_DAY)    m[16:12] = '0;
    if (g <= tlrq_pkg::GRAN_MONTH)  m[21:17] = '0;
    if (g == tlrq_pkg::GRAN_YEAR)   m[25:22] = '0;
    return m;
  endfunction

  task automatic owe_result(input log_result_t r);
    owed_mem[owed_wr % OWED_DEPTH] = r;
    owed_wr++;
  endtask

  task automatic predict_command(input logic cmd, input logic [tlrq_pkg::ID_W-1:0] id,
                                 input logic [tlrq_pkg::STAMP_W-1:0] start,
                                 input logic [tlrq_pkg::STAMP_W-1:0] stop,
                                 input logic [tlrq_pkg::GRAN_W-1:0] g);
    logic [tlrq_pkg::STAMP_W-1:0] m;
    logic [tlrq_pkg::STAMP_W-1:0] lo;
    logic [tlrq_pkg::STAMP_W-1:0] hi;
    logic [tlrq_pkg::STAMP_W-1:0] t;
    log_result_t                  r;
    log_result_t                  prev;
    logic                         have_prev;
    r.id   = '0;
    r.last = 1'b1;
    if (cmd == tlrq_pkg::CMD_STORE) begin
      if (rec_count >= DEPTH) begin
        r.status = tlrq_pkg::STAT_FULL;
        stores_dropped++;
      end else begin
        rec_stamp[rec_count] = start;
        rec_id[rec_count]    = id;
        rec_count++;
        r.status = tlrq_pkg::STAT_STORED;
        stores_kept++;
      end
      owe_result(r);
    end else begin
      queries_seen++;
      m  = granule_mask(g);
      lo = start & m;
      hi = stop & m;
      have_prev = 1'b0;
      prev      = '0;
      // hold back each hit by one so the final one can carry last
      for (int i = 0; i < rec_count; i++) begin
        t = rec_stamp[i] & m;
        if (t >= lo && t <= hi) begin
          if (have_prev) owe_result(prev);
          prev.id     = rec_id[i];
          prev.status = tlrq_pkg::STAT_MATCH;
          prev.last   = 1'b0;
          have_prev   = 1'b1;
          ids_matched++;
        end
      end
      if (have_prev) begin
        prev.last = 1'b1;
        owe_result(prev);
      end else begin
        r.status = tlrq_pkg::STAT_NONE;
        owe_result(r);
        queries_empty++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // results first: a transaction taken at this edge cannot answer itself
      if (out_valid && out_ready) begin
        if (owed_wr == owed_rd) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("[%0t] unexpected result: id=%h status=%0d last=%0b",
                     $realtime, out_match_id, out_status, out_last);
        end else begin
          want = owed_mem[owed_rd % OWED_DEPTH];
          owed_rd++;
          if (out_match_id !== want.id || out_status !== want.status ||
              out_last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("[%0t] mismatch: exp id=%h st=%0d last=%0b, got id=%h st=%0d last=%0b",
                       $realtime, want.id, want.status, want.last,
                       out_match_id, out_status, out_last);
          end
        end
      end
      if (in_valid && in_ready)
        predict_command(in_command, in_log_id, in_stamp, in_stamp_end, in_granularity);
      results_owed = owed_wr - owed_rd;
    end
  end

endmodule

### verif/timestamp_log_range_query_test.sv
// Top of the timestamp log testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module timestamp_log_range_query_test;

  localparam int CYCLE_LIMIT  = 500000; // ~170 queries x 64 ids under heavy stalls, many times over
  localparam int DRAIN_CYCLES = 80;     // extra wait after the last owed result is taken
  localparam int HOLD_CYCLES  = 300;    // long output stall to back up the input
  localparam int STORE_PCT    = 35;     // share of stores in the random part
  localparam int GW           = tlrq_pkg::GRAN_W;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic                           in_command     = tlrq_pkg::CMD_STORE;
  logic [tlrq_pkg::ID_W-1:0]      in_log_id      = '0;
  logic [tlrq_pkg::STAMP_W-1:0]   in_stamp       = '0;
  logic [tlrq_pkg::STAMP_W-1:0]   in_stamp_end   = '0;
  logic [tlrq_pkg::GRAN_W-1:0]    in_granularity = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [tlrq_pkg::ID_W-1:0]      out_match_id;
  logic [tlrq_pkg::STAT_W-1:0]    out_status;
  logic                           out_last;

  int err_cnt;
  int results_owed;
  int stores_kept;
  int stores_dropped;
  int queries_seen;
  int ids_matched;
  int queries_empty;

  // idle rates in percent, changed per phase by the stimulus
  int send_idle_pct = 35;
  int recv_idle_pct = 75;

  // long receiver hold-off, requested once by the stimulus
  logic hold_armed = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  int cycle_cnt = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  timestamp_log_range_query dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_log_id      (in_log_id),
    .in_stamp       (in_stamp),
    .in_stamp_end   (in_stamp_end),
    .in_granularity (in_granularity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_id   (out_match_id),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  timestamp_log_range_query_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_log_id      (in_log_id),
    .in_stamp       (in_stamp),
    .in_stamp_end   (in_stamp_end),
    .in_granularity (in_granularity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_id   (out_match_id),
    .out_status     (out_status),
    .out_last       (out_last),
    .err_cnt        (err_cnt),
    .results_owed   (results_owed),
    .stores_kept    (stores_kept),
    .stores_dropped (stores_dropped),
    .queries_seen   (queries_seen),
    .ids_matched    (ids_matched),
    .queries_empty  (queries_empty)
  );

  // Packs year / month / day / hour / minute / second, most significant first.
  function automatic logic [tlrq_pkg::STAMP_W-1:0] pack_stamp(
    input int yr, input int mo, input int dy, input int hr, input int mn, input int sc);
    return {yr[13:0], mo[3:0], dy[4:0], hr[4:0], mn[5:0], sc[5:0]};
  endfunction

  // Mostly calendar-like stamps from a narrow window so ranges hit stored
  // records at every granularity; the rest exercise every field bit.
  function automatic logic [tlrq_pkg::STAMP_W-1:0] random_stamp();
    int         pick;
    logic [7:0] top8;
    pick = $urandom_range(0, 99);
    top8 = 8'($urandom_range(0, 255));
    if (pick < 10)
      return {top8, 32'($urandom)};
    if (pick < 25)
      return pack_stamp($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    return pack_stamp(2024 + $urandom_range(0, 1), $urandom_range(1, 3), $urandom_range(1, 4),
                      $urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 59));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid drops only for idle cycles, so back-to-back transactions keep it high.
  task automatic offer_transaction(input logic cmd, input logic [tlrq_pkg::ID_W-1:0] id,
                                   input logic [tlrq_pkg::STAMP_W-1:0] start,
                                   input logic [tlrq_pkg::STAMP_W-1:0] stop,
                                   input logic [tlrq_pkg::GRAN_W-1:0] g);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_log_id      <= id;
    in_stamp       <= start;
    in_stamp_end   <= stop;
    in_granularity <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Unused fields of a store or a query still carry random values.
  task automatic store_record(input logic [tlrq_pkg::ID_W-1:0] id,
                              input logic [tlrq_pkg::STAMP_W-1:0] stamp);
    offer_transaction(tlrq_pkg::CMD_STORE, id, stamp, random_stamp(),
                      GW'($urandom_range(0, 7)));
  endtask

  task automatic run_query(input logic [tlrq_pkg::STAMP_W-1:0] start,
                           input logic [tlrq_pkg::STAMP_W-1:0] stop,
                           input logic [tlrq_pkg::GRAN_W-1:0] g);
    offer_transaction(tlrq_pkg::CMD_QUERY, $urandom, start, stop, g);
  endtask

  task automatic random_phase(input int n, input int send_pct, input int recv_pct);
    logic [tlrq_pkg::STAMP_W-1:0] a;
    logic [tlrq_pkg::STAMP_W-1:0] b;
    logic [tlrq_pkg::STAMP_W-1:0] t;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) begin
      if ($urandom_range(0, 99) < STORE_PCT) begin
        store_record($urandom, random_stamp());
      end else begin
        a = random_stamp();
        b = random_stamp();
        // mostly ordered ranges, some reversed ones that come back empty unless both ends share a granule
        if (a > b && $urandom_range(0, 99) < 85) begin
          t = a;
          a = b;
          b = t;
        end
        run_query(a, b, GW'($urandom_range(0, 7)));
      end
    end
  endtask

  // Receiver: random ready, except during the one long hold-off.
  always @(negedge clk) begin
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, results_owed);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [tlrq_pkg::STAMP_W-1:0] ref_stamp;
    ref_stamp = pack_stamp(2024, 6, 15, 12, 30, 45);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, sender 35% idle, receiver 75% idle
    send_idle_pct = 35;
    recv_idle_pct = 75;
    run_query('0, '1, tlrq_pkg::GRAN_YEAR);              // empty log: not found
    store_record('0, '0);                                // all-zero record
    store_record('1, '1);                                // all-ones record
    store_record(32'hA5A5_5A5A, ref_stamp);
    store_record(32'h0000_0011, pack_stamp(2024, 6, 15, 12, 30, 10));
    store_record(32'h0000_0022, pack_stamp(2024, 6, 15, 12, 31, 0));
    store_record(32'h0000_0033, pack_stamp(2024, 6, 15, 13, 0, 0));
    store_record(32'h0000_0044, pack_stamp(2024, 6, 16, 8, 0, 0));
    store_record(32'h0000_0055, pack_stamp(2024, 7, 1, 0, 0, 0));
    store_record(32'h0000_0066, pack_stamp(2025, 1, 1, 0, 0, 0));
    // one point range at every granularity code: the hit set shrinks with finer codes,
    // and the codes past minute behave like second
    for (int g = 0; g < 8; g++) run_query(ref_stamp, ref_stamp, GW'(g));
    run_query('0, '1, GW'(tlrq_pkg::GRAN_MINUTE + 1));   // whole range: every record
    run_query(pack_stamp(2025, 1, 1, 0, 0, 0), ref_stamp,
              tlrq_pkg::GRAN_DAY);                       // start after end
    run_query(pack_stamp(2024, 6, 15, 12, 30, 10), ref_stamp,
              GW'(tlrq_pkg::GRAN_MINUTE + 1));           // both ends in

    // random part; the log fills up on the way and later stores get dropped
    random_phase(70, 35, 75);
    random_phase(80, 75, 35);
    // no idling, with a long output stall at the start: the sender keeps offering
    // until the block backs up and drops in_ready
    hold_armed = 1'b1;
    random_phase(90, 0, 0);
    in_valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d stores kept and %0d dropped on a full log, %0d range queries",
             stores_kept, stores_dropped, queries_seen);
    $display("  returning %0d ids and %0d not-found answers, under three idle mixes",
             ids_matched, queries_empty);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d result errors", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
